### rtl/lwbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lwbc_pkg
// Shared types and constants of the LRU write-back block cache directory.
// ----------------------------------------------------------------------------
package lwbc_pkg;

    localparam int ENTRIES      = 16;
    localparam int SLOT_W       = $clog2(ENTRIES);
    localparam int SECTOR_SHIFT = 9;              // 512-byte sectors
    localparam int BB_W         = 17;             // block_bytes width
    localparam int SPB_W        = BB_W - SECTOR_SHIFT;
    localparam int TAG_W        = 32;
    localparam int STAMP_W      = 64;
    localparam int PADDR_W      = 3;

    localparam logic [TAG_W-1:0] INVALID_TAG   = 32'hFFFF_FFFF;
    localparam logic [BB_W-1:0]  BB_RESET      = 17'd512;
    localparam logic [SLOT_W-1:0] LAST_SLOT    = SLOT_W'(ENTRIES - 1);

    // request codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_WB    = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_FLUSH = 2'd3;

    // register index of block_bytes
    localparam logic REG_BLOCK_BYTES = 1'b0;

    // running result of a directory scan
    typedef struct packed {
        logic                   match_found;
        logic [SLOT_W-1:0]      match_slot;
        logic [SLOT_W-1:0]      victim_slot;
        logic [TAG_W-1:0]       victim_tag;
        logic                   victim_dirty;
        logic [STAMP_W-1:0]     victim_stamp;
    } scan_result_t;

endpackage
`default_nettype wire

### rtl/lwbc_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lwbc_scan
// Shared tag/stamp compare unit: visits one entry per cycle while en is high, tracking the
// first tag match and the oldest entry (ties keep the lower slot).
// ----------------------------------------------------------------------------
module lwbc_scan
    import lwbc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic [SLOT_W-1:0]   idx,
    input  wire logic [TAG_W-1:0]    tag,
    input  wire logic [STAMP_W-1:0]  stamp,
    input  wire logic                dirty,
    input  wire logic [TAG_W-1:0]    blk,
    output scan_result_t             res
);

    scan_result_t res_reg;
    scan_result_t res_next;
    logic         first;
    logic         is_match;
    logic         older;

    assign first    = (idx == '0);
    assign is_match = (tag == blk);
    assign older    = (stamp < res_reg.victim_stamp);

    // compare current entry against running best
    always_comb
    begin
        res_next = res_reg;
        if (first)
        begin
            res_next.match_found  = is_match;
            res_next.match_slot   = idx;
            res_next.victim_slot  = idx;
            res_next.victim_tag   = tag;
            res_next.victim_dirty = dirty;
            res_next.victim_stamp = stamp;
        end
        else
        begin
            if (is_match && !res_reg.match_found)
            begin
                res_next.match_found = 1'b1;
                res_next.match_slot  = idx;
            end
            if (older)
            begin
                res_next.victim_slot  = idx;
                res_next.victim_tag   = tag;
                res_next.victim_dirty = dirty;
                res_next.victim_stamp = stamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

### rtl/lwbc_sector_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lwbc_sector_mul
// Registered block-to-sector multiplier: block * sectors_per_block mod 2^32.
// ----------------------------------------------------------------------------
module lwbc_sector_mul
    import lwbc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic [TAG_W-1:0]    blk,
    input  wire logic [SPB_W-1:0]    spb,
    output logic [TAG_W-1:0]         sector
);

    logic [TAG_W+SPB_W-1:0] product;
    logic [TAG_W-1:0]       sector_reg;

    assign product = {{SPB_W{1'b0}}, blk} * {{TAG_W{1'b0}}, spb};

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        sector_reg <= product[TAG_W-1:0];
    end

    assign sector = sector_reg;

endmodule
`default_nettype wire

### rtl/lru_writeback_block_cache_directory.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_writeback_block_cache_directory
// Directory and LRU policy of a 16-entry fully associative write-back cache.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A read or write
// scans all 16 entries through one compare unit, one entry per cycle, then
// decides: a hit gives a done result; a miss gives a write-back result if
// the LRU victim is dirty, allocates it, gives a load result unless a write
// covers the whole block, then a done result. A flush gives a write-back
// result for each valid dirty entry and clears its dirty bit, then a
// flush-done result. A read or write of an invalid block gets one done
// result, no scan; op 3 gives none. Each result's result_valid is high for
// a single cycle; the receiver must take them, there is no back-pressure.
// ----------------------------------------------------------------------------
module lru_writeback_block_cache_directory
    import lwbc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // request
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          op,
    input  wire logic [31:0]         block_id,
    input  wire logic [15:0]         block_offset,
    input  wire logic [16:0]         length,
    // results
    output logic                     result_valid,
    output logic [1:0]               kind,
    output logic [3:0]               slot,
    output logic [31:0]              target_block,
    output logic [31:0]              sector_start,
    output logic [7:0]               sector_count,
    output logic                     hit,
    output logic                     last,
    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_WB,
        ST_ALLOC,
        ST_LOAD,
        ST_DONE,
        ST_FL_READ,
        ST_FL_EMIT,
        ST_FL_DONE
    } state_t;

    state_t state_reg;

    // directory
    logic [TAG_W-1:0]    tag_reg   [ENTRIES];
    logic                dirty_reg [ENTRIES];
    logic [STAMP_W-1:0]  stamp_reg [ENTRIES];
    logic [STAMP_W-1:0]  count_reg;

    // request and sequencer
    logic [BB_W-1:0]     block_bytes_reg;
    logic [1:0]          op_reg;
    logic [TAG_W-1:0]    blk_reg;
    logic                full_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic [SLOT_W-1:0]   slot_sel_reg;
    logic [TAG_W-1:0]    tag_sel_reg;

    // result registers
    logic                rv_reg;
    logic [1:0]          kind_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [TAG_W-1:0]    target_reg;
    logic [TAG_W-1:0]    sector_reg;
    logic [SPB_W-1:0]    count_out_reg;
    logic                hit_reg;
    logic                last_reg;

    logic [SPB_W-1:0]    spb;
    logic [TAG_W-1:0]    mul_blk;
    logic [TAG_W-1:0]    mul_sector;
    logic                accept;
    logic                cfg_wr;
    logic                load_needed;
    scan_result_t        scan;

    assign spb     = block_bytes_reg[BB_W-1:SECTOR_SHIFT];
    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_BLOCK_BYTES);
    assign prdata  = (paddr[2] == REG_BLOCK_BYTES) ? {15'd0, block_bytes_reg} : 32'd0;
    assign load_needed = (op_reg == OP_READ) || !full_reg;

    // compare unit over the directory
    lwbc_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (state_reg == ST_SCAN),
        .idx   (idx_reg),
        .tag   (tag_reg[idx_reg]),
        .stamp (stamp_reg[idx_reg]),
        .dirty (dirty_reg[idx_reg]),
        .blk   (blk_reg),
        .res   (scan)
    );

    // multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_DECIDE:  mul_blk = scan.victim_tag;
            ST_FL_READ: mul_blk = tag_reg[idx_reg];
            default:    mul_blk = blk_reg;
        endcase
    end

    lwbc_sector_mul u_mul (
        .clk    (clk),
        .blk    (mul_blk),
        .spb    (spb),
        .sector (mul_sector)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg <= BB_RESET;
        end
        else if (cfg_wr)
        begin
            block_bytes_reg <= pwdata[BB_W-1:0];
        end
    end

    // sequencer, directory and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < ENTRIES; i++)
            begin
                tag_reg[i]   <= INVALID_TAG;
                dirty_reg[i] <= 1'b0;
                stamp_reg[i] <= '0;
            end
            count_reg     <= '0;
            op_reg        <= OP_READ;
            blk_reg       <= '0;
            full_reg      <= 1'b0;
            idx_reg       <= '0;
            slot_sel_reg  <= '0;
            tag_sel_reg   <= '0;
            rv_reg        <= 1'b0;
            kind_reg      <= KIND_DONE;
            slot_reg      <= '0;
            target_reg    <= '0;
            sector_reg    <= '0;
            count_out_reg <= '0;
            hit_reg       <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            rv_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg   <= op;
                        blk_reg  <= block_id;
                        full_reg <= (block_offset == 16'd0) && (length == block_bytes_reg);
                        idx_reg  <= '0;
                        if (op == OP_FLUSH)
                        begin
                            state_reg <= ST_FL_READ;
                        end
                        else if (op != OP_NONE)
                        begin
                            if (block_id == INVALID_TAG)
                            begin
                                // invalid block: single access-done result
                                rv_reg        <= 1'b1;
                                kind_reg      <= KIND_DONE;
                                slot_reg      <= '0;
                                target_reg    <= block_id;
                                sector_reg    <= '0;
                                count_out_reg <= '0;
                                hit_reg       <= 1'b0;
                                last_reg      <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= ST_SCAN;
                            end
                        end
                    end
                end

                ST_SCAN:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == LAST_SLOT)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end

                ST_DECIDE:
                begin
                    if (scan.match_found)
                    begin
                        // hit: refresh, mark dirty on a write
                        stamp_reg[scan.match_slot] <= count_reg;
                        count_reg <= count_reg + 1'b1;
                        if (op_reg == OP_WRITE)
                        begin
                            dirty_reg[scan.match_slot] <= 1'b1;
                        end
                        rv_reg        <= 1'b1;
                        kind_reg      <= KIND_DONE;
                        slot_reg      <= scan.match_slot;
                        target_reg    <= blk_reg;
                        sector_reg    <= '0;
                        count_out_reg <= '0;
                        hit_reg       <= 1'b1;
                        last_reg      <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        slot_sel_reg <= scan.victim_slot;
                        tag_sel_reg  <= scan.victim_tag;
                        if (scan.victim_dirty && (scan.victim_tag != INVALID_TAG))
                        begin
                            state_reg <= ST_WB;
                        end
                        else
                        begin
                            state_reg <= ST_ALLOC;
                        end
                    end
                end

                ST_WB:
                begin
                    rv_reg        <= 1'b1;
                    kind_reg      <= KIND_WB;
                    slot_reg      <= slot_sel_reg;
                    target_reg    <= tag_sel_reg;
                    sector_reg    <= mul_sector;
                    count_out_reg <= spb;
                    hit_reg       <= 1'b0;
                    last_reg      <= 1'b0;
                    state_reg     <= ST_ALLOC;
                end

                ST_ALLOC:
                begin
                    // take the victim for the requested block
                    tag_reg[slot_sel_reg]   <= blk_reg;
                    dirty_reg[slot_sel_reg] <= (op_reg == OP_WRITE) && full_reg;
                    stamp_reg[slot_sel_reg] <= count_reg;
                    count_reg               <= count_reg + 1'b1;
                    state_reg <= load_needed ? ST_LOAD : ST_DONE;
                end

                ST_LOAD:
                begin
                    rv_reg        <= 1'b1;
                    kind_reg      <= KIND_LOAD;
                    slot_reg      <= slot_sel_reg;
                    target_reg    <= blk_reg;
                    sector_reg    <= mul_sector;
                    count_out_reg <= spb;
                    hit_reg       <= 1'b0;
                    last_reg      <= 1'b0;
                    // partial write miss: second access after the load
                    if (op_reg == OP_WRITE)
                    begin
                        dirty_reg[slot_sel_reg] <= 1'b1;
                        stamp_reg[slot_sel_reg] <= count_reg;
                        count_reg               <= count_reg + 1'b1;
                    end
                    state_reg <= ST_DONE;
                end

                ST_DONE:
                begin
                    rv_reg        <= 1'b1;
                    kind_reg      <= KIND_DONE;
                    slot_reg      <= slot_sel_reg;
                    target_reg    <= blk_reg;
                    sector_reg    <= '0;
                    count_out_reg <= '0;
                    hit_reg       <= 1'b0;
                    last_reg      <= 1'b1;
                    state_reg     <= ST_IDLE;
                end

                ST_FL_READ:
                begin
                    if (dirty_reg[idx_reg] && (tag_reg[idx_reg] != INVALID_TAG))
                    begin
                        slot_sel_reg <= idx_reg;
                        tag_sel_reg  <= tag_reg[idx_reg];
                        state_reg    <= ST_FL_EMIT;
                    end
                    else if (idx_reg == LAST_SLOT)
                    begin
                        state_reg <= ST_FL_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end

                ST_FL_EMIT:
                begin
                    dirty_reg[slot_sel_reg] <= 1'b0;
                    rv_reg        <= 1'b1;
                    kind_reg      <= KIND_WB;
                    slot_reg      <= slot_sel_reg;
                    target_reg    <= tag_sel_reg;
                    sector_reg    <= mul_sector;
                    count_out_reg <= spb;
                    hit_reg       <= 1'b0;
                    last_reg      <= 1'b0;
                    if (idx_reg == LAST_SLOT)
                    begin
                        state_reg <= ST_FL_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_FL_READ;
                    end
                end

                ST_FL_DONE:
                begin
                    rv_reg        <= 1'b1;
                    kind_reg      <= KIND_FLUSH;
                    slot_reg      <= '0;
                    target_reg    <= '0;
                    sector_reg    <= '0;
                    count_out_reg <= '0;
                    hit_reg       <= 1'b0;
                    last_reg      <= 1'b1;
                    state_reg     <= ST_IDLE;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = rv_reg;
    assign kind         = kind_reg;
    assign slot         = slot_reg;
    assign target_block = target_reg;
    assign sector_start = sector_reg;
    assign sector_count = count_out_reg;
    assign hit          = hit_reg;
    assign last         = last_reg;

endmodule
`default_nettype wire
